// ----- rtl/ates_pkg.sv -----
// ----------------------------------------------------------------------------
// ates_pkg
// Shared types, constants and the color palette of the terminal screen engine.
// ----------------------------------------------------------------------------
package ates_pkg;

    localparam int ROWS_DEF = 24;
    localparam int COLS_DEF = 80;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_K      = 8'h4B;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [3:0] COLOR_BLACK = 4'd0;
    localparam logic [3:0] COLOR_WHITE = 4'd7;
    localparam logic [3:0] COLOR_GRAY  = 4'd8;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_GLYPH,
        OP_GLYPH2,
        OP_CLEAR,
        OP_ERASE,
        OP_READ
    } op_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_FILL,
        BK_READ,
        BK_READ2,
        BK_OUT
    } bk_state_t;

    // One command handed from the parser to the executor.
    typedef struct packed {
        op_t        op;
        logic [7:0] glyph;
        logic [7:0] glyph2;
        logic [3:0] fg;
        logic [3:0] bg;
        logic       bold;
        logic [4:0] row;
        logic [6:0] col;
        logic [4:0] cur_row;
        logic [6:0] cur_col;
    } cmd_t;

    function automatic logic [23:0] palette(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0: rgb = 24'h000000;
            4'd1: rgb = 24'hFF0000;
            4'd2: rgb = 24'h00FF00;
            4'd3: rgb = 24'hFFFF00;
            4'd4: rgb = 24'h0000FF;
            4'd5: rgb = 24'hFF00FF;
            4'd6: rgb = 24'h00FFFF;
            4'd7: rgb = 24'hFFFFFF;
            4'd8: rgb = 24'h787878;
            default: rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

endpackage

// ----- rtl/ates_if.sv -----
// ----------------------------------------------------------------------------
// ates_in_if / ates_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface ates_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_value;
    logic [4:0] read_row;
    logic [6:0] read_col;
    modport source (output valid, kind, byte_value, read_row, read_col, input ready);
    modport sink (input valid, kind, byte_value, read_row, read_col, output ready);
endinterface

interface ates_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  cell_char;
    logic [23:0] cell_fg_rgb;
    logic [23:0] cell_bg_rgb;
    logic        cell_bold;
    logic [4:0]  cursor_row_out;
    logic [6:0]  cursor_col_out;
    modport source (output valid, cell_char, cell_fg_rgb, cell_bg_rgb, cell_bold,
                    cursor_row_out, cursor_col_out, input ready);
    modport sink (input valid, cell_char, cell_fg_rgb, cell_bg_rgb, cell_bold,
                  cursor_row_out, cursor_col_out, output ready);
endinterface

// ----- rtl/ates_parser.sv -----
// ----------------------------------------------------------------------------
// ates_parser
// Front end: parses host bytes, tracks the cursor and attributes, and queues
// one command per input item for the executor.
// ----------------------------------------------------------------------------
module ates_parser #(
    parameter int ROWS = ates_pkg::ROWS_DEF,
    parameter int COLS = ates_pkg::COLS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    ates_in_if.sink        in_ch,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output ates_pkg::cmd_t cmd
);
    localparam logic [4:0] ROW_MAX = 5'(ROWS - 1);
    localparam logic [6:0] COL_MAX = 7'(COLS - 1);

    ates_pkg::phase_t phase_reg, phase_next;
    logic [4:0] row_reg, row_next;
    logic [6:0] col_reg, col_next;
    logic [3:0] afg_reg, afg_next, abg_reg, abg_next;
    logic       abold_reg, abold_next;
    logic [7:0] fv_reg, fv_next, v1_reg, v1_next;
    logic       fd_reg, fd_next, d1_reg, d1_next, d2_reg, d2_next, ne_reg, ne_next;
    logic [1:0] fc_reg, fc_next;
    logic [7:0] v2_reg, v2_next;
    logic [3:0] sfg_reg, sfg_next, sbg_reg, sbg_next;
    logic       sbold_reg, sbold_next;

    ates_pkg::cmd_t q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    ates_pkg::cmd_t item_cmd;
    logic       accept;
    logic [7:0] b;
    logic [11:0] acc;
    logic [7:0] code;
    logic [7:0] hr, hc;
    logic [4:0] gr;
    logic [6:0] gc;
    logic       do_code;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign accept = in_ch.valid && in_ch.ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = q_reg[rp_reg];
    assign pop = cmd_valid && cmd_ready;
    assign b = in_ch.byte_value;
    assign acc = 12'(fv_reg) * 12'd10 + 12'(b - ates_pkg::CH_ZERO);

    always_comb
    begin
        phase_next = phase_reg;
        row_next = row_reg;
        col_next = col_reg;
        afg_next = afg_reg;
        abg_next = abg_reg;
        abold_next = abold_reg;
        fv_next = fv_reg;
        fd_next = fd_reg;
        fc_next = fc_reg;
        v1_next = v1_reg;
        d1_next = d1_reg;
        v2_next = v2_reg;
        d2_next = d2_reg;
        ne_next = ne_reg;
        sfg_next = sfg_reg;
        sbg_next = sbg_reg;
        sbold_next = sbold_reg;
        code = 8'd0;
        do_code = 1'b0;
        hr = 8'd0;
        hc = 8'd0;
        gr = row_reg;
        gc = col_reg;
        item_cmd = '0;
        item_cmd.op = ates_pkg::OP_NONE;
        item_cmd.fg = afg_reg;
        item_cmd.bg = abg_reg;
        item_cmd.bold = abold_reg;
        item_cmd.row = row_reg;
        item_cmd.col = col_reg;
        if (in_ch.kind)
        begin
            item_cmd.op = ates_pkg::OP_READ;
            item_cmd.row = in_ch.read_row;
            item_cmd.col = in_ch.read_col;
        end
        else if (phase_reg == ates_pkg::PH_ESC && b == ates_pkg::CH_LBRACK)
        begin
            phase_next = ates_pkg::PH_CSI;
            fv_next = 8'd0; fd_next = 1'b0; fc_next = 2'd0;
            v1_next = 8'd0; d1_next = 1'b0; v2_next = 8'd0; d2_next = 1'b0;
            ne_next = 1'b0;
            sfg_next = afg_reg; sbg_next = abg_reg; sbold_next = abold_reg;
        end
        else if (phase_reg == ates_pkg::PH_CSI)
        begin
            if (b >= ates_pkg::CH_ZERO && b <= ates_pkg::CH_NINE)
            begin
                fv_next = (acc > 12'd255) ? 8'd255 : acc[7:0];
                fd_next = 1'b1;
                ne_next = 1'b1;
            end
            else if (b == ates_pkg::CH_SEMI)
            begin
                ne_next = 1'b1;
                code = fd_reg ? fv_reg : 8'd0;
                do_code = 1'b1;
                if (fc_reg == 2'd0)
                begin
                    v1_next = fv_reg; d1_next = fd_reg;
                end
                else if (fc_reg == 2'd1)
                begin
                    v2_next = fv_reg; d2_next = fd_reg;
                end
                if (fc_reg != 2'd3)
                begin
                    fc_next = fc_reg + 2'd1;
                end
                fv_next = 8'd0;
                fd_next = 1'b0;
            end
            else
            begin
                phase_next = ates_pkg::PH_TEXT;
                if (b == ates_pkg::CH_H)
                begin
                    if (fc_reg == 2'd0)
                    begin
                        hr = fd_reg ? fv_reg : 8'd0;
                    end
                    else
                    begin
                        hr = d1_reg ? v1_reg : 8'd0;
                        if (fc_reg == 2'd1)
                        begin
                            hc = (d1_reg && fd_reg) ? fv_reg : 8'd0;
                        end
                        else
                        begin
                            hc = (d1_reg && d2_reg) ? v2_reg : 8'd0;
                        end
                    end
                    row_next = (hr >= 8'd1 && 9'(hr) <= 9'(ROWS)) ? 5'(hr - 8'd1) : 5'd0;
                    col_next = (hc >= 8'd1 && 9'(hc) <= 9'(COLS)) ? 7'(hc - 8'd1) : 7'd0;
                end
                else if (b == ates_pkg::CH_J)
                begin
                    item_cmd.op = ates_pkg::OP_CLEAR;
                    row_next = 5'd0;
                    col_next = 7'd0;
                end
                else if (b == ates_pkg::CH_K)
                begin
                    item_cmd.op = ates_pkg::OP_ERASE;
                end
                else if (b == ates_pkg::CH_M)
                begin
                    if (!ne_reg)
                    begin
                        code = 8'd0; do_code = 1'b1;
                    end
                    else if (fd_reg)
                    begin
                        code = fv_reg; do_code = 1'b1;
                    end
                end
            end
        end
        else
        begin
            if (phase_reg == ates_pkg::PH_ESC)
            begin
                item_cmd.op = ates_pkg::OP_GLYPH;
                item_cmd.glyph = ates_pkg::CH_ESC;
                if (col_reg == COL_MAX)
                begin
                    gc = 7'd0;
                    gr = (row_reg == ROW_MAX) ? ROW_MAX : row_reg + 5'd1;
                end
                else
                begin
                    gc = col_reg + 7'd1;
                end
                phase_next = ates_pkg::PH_TEXT;
            end
            if (b == ates_pkg::CH_ESC)
            begin
                phase_next = ates_pkg::PH_ESC;
                row_next = gr;
                col_next = gc;
            end
            else
            begin
                item_cmd.op = (phase_reg == ates_pkg::PH_ESC) ? ates_pkg::OP_GLYPH2
                                                                : ates_pkg::OP_GLYPH;
                if (phase_reg == ates_pkg::PH_ESC)
                begin
                    item_cmd.glyph2 = b;
                end
                else
                begin
                    item_cmd.glyph = b;
                end
                item_cmd.row = row_reg;
                item_cmd.col = col_reg;
                if (gc == COL_MAX)
                begin
                    col_next = 7'd0;
                    row_next = (gr == ROW_MAX) ? ROW_MAX : gr + 5'd1;
                end
                else
                begin
                    col_next = gc + 7'd1;
                    row_next = gr;
                end
            end
        end
        if (do_code)
        begin
            if (code == 8'd0)
            begin
                sfg_next = ates_pkg::COLOR_WHITE;
                sbg_next = ates_pkg::COLOR_BLACK;
                sbold_next = 1'b0;
            end
            else if (code == 8'd1)
            begin
                sbold_next = 1'b1;
            end
            else if (code >= 8'd30 && code <= 8'd37)
            begin
                sfg_next = 4'(code - 8'd30);
            end
            else if (code >= 8'd40 && code <= 8'd47)
            begin
                sbg_next = 4'(code - 8'd40);
            end
        end
        if (!in_ch.kind && phase_reg == ates_pkg::PH_CSI && b == ates_pkg::CH_M)
        begin
            afg_next = sfg_next;
            abg_next = sbg_next;
            abold_next = sbold_next;
        end
        // Cursor after the item travels with the command for the result.
        item_cmd.cur_row = row_next;
        item_cmd.cur_col = col_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ates_pkg::PH_TEXT;
            row_reg <= 5'd0; col_reg <= 7'd0;
            afg_reg <= ates_pkg::COLOR_WHITE; abg_reg <= ates_pkg::COLOR_GRAY;
            abold_reg <= 1'b0;
            fv_reg <= 8'd0; fd_reg <= 1'b0; fc_reg <= 2'd0;
            v1_reg <= 8'd0; d1_reg <= 1'b0; v2_reg <= 8'd0; d2_reg <= 1'b0;
            ne_reg <= 1'b0;
            sfg_reg <= ates_pkg::COLOR_WHITE; sbg_reg <= ates_pkg::COLOR_GRAY;
            sbold_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            row_reg <= row_next; col_reg <= col_next;
            afg_reg <= afg_next; abg_reg <= abg_next; abold_reg <= abold_next;
            fv_reg <= fv_next; fd_reg <= fd_next; fc_reg <= fc_next;
            v1_reg <= v1_next; d1_reg <= d1_next; v2_reg <= v2_next; d2_reg <= d2_next;
            ne_reg <= ne_next;
            sfg_reg <= sfg_next; sbg_reg <= sbg_next; sbold_reg <= sbold_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(accept) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wp_reg] <= item_cmd;
        end
    end
endmodule

// ----- rtl/ates_exec.sv -----
// ----------------------------------------------------------------------------
// ates_exec
// Back end: owns the cell memory, runs clear and erase sweeps, writes glyphs,
// reads cells and presents one registered result per command.
// ----------------------------------------------------------------------------
module ates_exec #(
    parameter int ROWS = ates_pkg::ROWS_DEF,
    parameter int COLS = ates_pkg::COLS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  ates_pkg::cmd_t cmd,
    ates_out_if.source     out_ch
);
    localparam int DEPTH = ROWS * COLS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [6:0] COL_MAX = 7'(COLS - 1);

    logic [16:0] mem [DEPTH];

    ates_pkg::bk_state_t st_reg, st_next;
    ates_pkg::cmd_t c_reg;
    logic [AW-1:0] addr_reg, addr_next, end_reg;
    logic [3:0]  ffg_reg, fbg_reg;
    logic        ovalid_reg, inr_reg;
    logic [16:0] rd_reg;
    logic        we;
    logic [AW-1:0] wa;
    logic [16:0] wd;
    logic [AW-1:0] base;
    logic        load;

    assign base = AW'(c_reg.row) * AW'(COLS) + AW'(c_reg.col);
    assign cmd_ready = (st_reg == ates_pkg::BK_IDLE) && !ovalid_reg;
    assign load = cmd_valid && cmd_ready;

    always_comb
    begin
        st_next = st_reg;
        addr_next = addr_reg;
        unique case (st_reg)
            ates_pkg::BK_INIT:
            begin
                addr_next = addr_reg + AW'(1);
                if (addr_reg == LAST)
                begin
                    st_next = ates_pkg::BK_IDLE;
                end
            end
            ates_pkg::BK_IDLE:
            begin
                if (load)
                begin
                    unique case (cmd.op)
                        ates_pkg::OP_CLEAR: st_next = ates_pkg::BK_FILL;
                        ates_pkg::OP_ERASE: st_next = ates_pkg::BK_FILL;
                        ates_pkg::OP_READ:  st_next = ates_pkg::BK_READ;
                        ates_pkg::OP_GLYPH2: st_next = ates_pkg::BK_READ2;
                        default:            st_next = ates_pkg::BK_OUT;
                    endcase
                end
            end
            ates_pkg::BK_FILL:
            begin
                addr_next = addr_reg + AW'(1);
                if (addr_reg == end_reg)
                begin
                    st_next = ates_pkg::BK_OUT;
                end
            end
            ates_pkg::BK_READ:  st_next = ates_pkg::BK_OUT;
            ates_pkg::BK_READ2: st_next = ates_pkg::BK_OUT;
            ates_pkg::BK_OUT:   st_next = ates_pkg::BK_IDLE;
            default:            st_next = ates_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        we = 1'b0;
        wa = addr_reg;
        wd = {ates_pkg::CH_SPACE, ffg_reg, fbg_reg, 1'b0};
        unique case (st_reg)
            ates_pkg::BK_INIT:
            begin
                we = 1'b1;
                wd = {ates_pkg::CH_SPACE, ates_pkg::COLOR_WHITE, ates_pkg::COLOR_GRAY, 1'b0};
            end
            ates_pkg::BK_FILL:
            begin
                we = 1'b1;
            end
            ates_pkg::BK_READ2:
            begin
                we = 1'b1;
                wa = base;
                wd = {c_reg.glyph, c_reg.fg, c_reg.bg, c_reg.bold};
            end
            ates_pkg::BK_OUT:
            begin
                we = (c_reg.op == ates_pkg::OP_GLYPH) || (c_reg.op == ates_pkg::OP_GLYPH2);
                wa = base;
                wd = {c_reg.glyph, c_reg.fg, c_reg.bg, c_reg.bold};
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[base];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            c_reg <= cmd;
            ffg_reg <= cmd.fg;
            fbg_reg <= cmd.bg;
            inr_reg <= (32'(cmd.row) < ROWS) && (32'(cmd.col) < COLS);
        end
        else if (st_reg == ates_pkg::BK_READ2)
        begin
            // Write the escape glyph first, then the byte at the next position.
            c_reg.glyph <= c_reg.glyph2;
            c_reg.col <= (c_reg.col == COL_MAX) ? 7'd0 : c_reg.col + 7'd1;
            c_reg.row <= (c_reg.col == COL_MAX) ?
                         ((32'(c_reg.row) == ROWS - 1) ? c_reg.row : c_reg.row + 5'd1) :
                         c_reg.row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ates_pkg::BK_INIT;
            addr_reg <= '0;
            end_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            addr_reg <= addr_next;
            if (load && cmd.op == ates_pkg::OP_CLEAR)
            begin
                addr_reg <= '0;
                end_reg <= LAST;
            end
            else if (load && cmd.op == ates_pkg::OP_ERASE)
            begin
                addr_reg <= AW'(cmd.row) * AW'(COLS) + AW'(cmd.col);
                end_reg <= AW'(cmd.row) * AW'(COLS) + AW'(COLS - 1);
            end
            if (st_reg == ates_pkg::BK_OUT)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    logic is_rd;
    assign is_rd = (c_reg.op == ates_pkg::OP_READ) && inr_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.cell_char = is_rd ? rd_reg[16:9] : 8'd0;
    assign out_ch.cell_fg_rgb = is_rd ? ates_pkg::palette(rd_reg[8:5]) : 24'd0;
    assign out_ch.cell_bg_rgb = is_rd ? ates_pkg::palette(rd_reg[4:1]) : 24'd0;
    assign out_ch.cell_bold = is_rd ? rd_reg[0] : 1'b0;
    assign out_ch.cursor_row_out = c_reg.cur_row;
    assign out_ch.cursor_col_out = c_reg.cur_col;
endmodule

// ----- rtl/ansi_terminal_screen_engine_core.sv -----
// ----------------------------------------------------------------------------
// ansi_terminal_screen_engine_core
// Terminal screen engine: parser front end and cell memory back end.
// Text passes the back end states IDLE and OUT; reads and ESC plus a glyph add
// READ or READ2, an erase or a clear a FILL sweep over the row's rest or the
// whole screen. The back end runs one command at a time and takes no new one
// before its result is taken; a two-entry queue lets the parser run ahead.
// Results are held until taken. After reset a clearing pass runs first.
// ----------------------------------------------------------------------------
module ansi_terminal_screen_engine_core #(
    parameter int ROWS = ates_pkg::ROWS_DEF,
    parameter int COLS = ates_pkg::COLS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ates_in_if.sink    in_ch,
    ates_out_if.source out_ch
);
    logic           cmd_valid, cmd_ready;
    ates_pkg::cmd_t cmd;

    ates_parser #(.ROWS(ROWS), .COLS(COLS)) u_parser (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    ates_exec #(.ROWS(ROWS), .COLS(COLS)) u_exec (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .out_ch(out_ch)
    );
endmodule
